/* hw/rtl/assert_macros.svh */
// Assertion macros used by triangle_box_overlap_2d.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/tbo_pkg.sv */
`default_nettype none
package tbo_pkg;
   localparam int COORD_WIDTH = 24;
   // Differences of two coordinates need one extra bit.
   localparam int DIFF_WIDTH = COORD_WIDTH + 1;
   localparam int PROD_WIDTH = 2 * DIFF_WIDTH;
   localparam int SUM_WIDTH = PROD_WIDTH + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0] diff_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [SUM_WIDTH-1:0] sum_type;

   typedef enum logic [1:0] {
      HIT_NONE   = 2'd0,
      HIT_VERTEX = 2'd1,
      HIT_EDGE   = 2'd2,
      HIT_CORNER = 2'd3
   } hit_type;
endpackage
`default_nettype wire

/* hw/rtl/triangle_box_overlap_2d.sv */
// Throughput: one item per cycle unless the output stalls; a four-stage pipeline of compares
// and 25x25-bit products, each result passing the stage 1 to 4 registers in order.
// A stall holds the run of full stages at the output; a free slot ahead lets a bubble be filled.
// Reset (synchronous, active high) clears all stage valid bits; data registers are not reset.
`default_nettype none
`include "assert_macros.svh"
module triangle_box_overlap_2d (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire tbo_pkg::coord_type req_box_left,
   input  wire tbo_pkg::coord_type req_box_top,
   input  wire tbo_pkg::coord_type req_box_right,
   input  wire tbo_pkg::coord_type req_box_bottom,
   input  wire tbo_pkg::coord_type req_ax,
   input  wire tbo_pkg::coord_type req_ay,
   input  wire tbo_pkg::coord_type req_bx,
   input  wire tbo_pkg::coord_type req_by,
   input  wire tbo_pkg::coord_type req_cx,
   input  wire tbo_pkg::coord_type req_cy,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic rsp_overlap,
   output logic [1:0] rsp_hit_kind
);
   // Edge e: 0=(A,B) 1=(B,C) 2=(A,C). Side tests j: 0 left,1 top,2 right,3 bottom.
   // Each side test compares lo <= mid <= hi with three products.

   // ---------------- Stage 1: differences and outcodes ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   logic [3:0] k_in [3];
   logic vtx_in, vtx1_ff;
   logic bb_in, bb1_ff;
   // Per edge: flags, vertical, vertical hit, sign-normalised vectors, dy zero, box offsets.
   logic [3:0] fl_in [3], fl1_ff [3];
   logic vert_in [3], vert1_ff [3];
   logic vhit_in [3], vhit1_ff [3];
   tbo_pkg::diff_type hx_in [3], hy_in [3], vx_in [3], vy_in [3];
   tbo_pkg::diff_type hx1_ff [3], hy1_ff [3], vx1_ff [3], vy1_ff [3];
   logic dyz_in [3], dyz1_ff [3];
   tbo_pkg::diff_type tp_in [3], bp_in [3], lp_in [3], rp_in [3];
   tbo_pkg::diff_type tp1_ff [3], bp1_ff [3], lp1_ff [3], rp1_ff [3];
   // Corner test operands: q - a for four corners, edge vectors.
   tbo_pkg::diff_type qx_in [4], qy_in [4], qx1_ff [4], qy1_ff [4];
   tbo_pkg::diff_type e0x1_ff, e0y1_ff, e1x1_ff, e1y1_ff;

   function automatic tbo_pkg::diff_type dif(tbo_pkg::coord_type a, tbo_pkg::coord_type b);
      return tbo_pkg::diff_type'(a) - tbo_pkg::diff_type'(b);
   endfunction

   function automatic logic [3:0] ocode(tbo_pkg::coord_type x, tbo_pkg::coord_type y);
      return {y > req_box_bottom, x > req_box_right, y > req_box_top, x > req_box_left};
   endfunction

   tbo_pkg::coord_type px [3], py [3], qxe [3], qye [3];
   always_comb begin
      px[0] = req_ax; py[0] = req_ay; qxe[0] = req_bx; qye[0] = req_by;
      px[1] = req_bx; py[1] = req_by; qxe[1] = req_cx; qye[1] = req_cy;
      px[2] = req_ax; py[2] = req_ay; qxe[2] = req_cx; qye[2] = req_cy;
      k_in[0] = ocode(req_ax, req_ay);
      k_in[1] = ocode(req_bx, req_by);
      k_in[2] = ocode(req_cx, req_cy);
      vtx_in = (k_in[0] == 4'd3) || (k_in[1] == 4'd3) || (k_in[2] == 4'd3);
      fl_in[0] = k_in[0] ^ k_in[1];
      fl_in[1] = k_in[1] ^ k_in[2];
      fl_in[2] = k_in[0] ^ k_in[2];
      for (int e = 0; e < 3; e++) begin
         tbo_pkg::diff_type dx, dy;
         dx = dif(qxe[e], px[e]);
         dy = dif(qye[e], py[e]);
         vert_in[e] = (dx == '0);
         vhit_in[e] = (px[e] == req_box_left) || (px[e] == req_box_right)
            || (px[e] > req_box_left && px[e] < req_box_right);
         hx_in[e] = dx[tbo_pkg::DIFF_WIDTH-1] ? -dx : dx;
         hy_in[e] = dx[tbo_pkg::DIFF_WIDTH-1] ? -dy : dy;
         vx_in[e] = dy[tbo_pkg::DIFF_WIDTH-1] ? -dx : dx;
         vy_in[e] = dy[tbo_pkg::DIFF_WIDTH-1] ? -dy : dy;
         dyz_in[e] = (dy == '0);
         tp_in[e] = dif(req_box_top, py[e]);
         bp_in[e] = dif(req_box_bottom, py[e]);
         lp_in[e] = dif(req_box_left, px[e]);
         rp_in[e] = dif(req_box_right, px[e]);
      end
      qx_in[0] = dif(req_box_left, req_ax);  qy_in[0] = dif(req_box_top, req_ay);
      qx_in[1] = dif(req_box_left, req_ax);  qy_in[1] = dif(req_box_bottom, req_ay);
      qx_in[2] = dif(req_box_right, req_ax); qy_in[2] = dif(req_box_bottom, req_ay);
      qx_in[3] = dif(req_box_right, req_ax); qy_in[3] = dif(req_box_top, req_ay);
      bb_in = (req_ax <= req_box_left || req_bx <= req_box_left || req_cx <= req_box_left)
         && (req_ax >= req_box_right || req_bx >= req_box_right || req_cx >= req_box_right)
         && (req_ay <= req_box_top || req_by <= req_box_top || req_cy <= req_box_top)
         && (req_ay >= req_box_bottom || req_by >= req_box_bottom
             || req_cy >= req_box_bottom);
   end

   // The pipeline advances stage by stage; a stage moves when the next one is free.
   assign en4 = !v4_ff || rsp_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         vtx1_ff <= vtx_in; bb1_ff <= bb_in;
         fl1_ff <= fl_in; vert1_ff <= vert_in; vhit1_ff <= vhit_in;
         hx1_ff <= hx_in; hy1_ff <= hy_in; vx1_ff <= vx_in; vy1_ff <= vy_in;
         dyz1_ff <= dyz_in;
         tp1_ff <= tp_in; bp1_ff <= bp_in; lp1_ff <= lp_in; rp1_ff <= rp_in;
         qx1_ff <= qx_in; qy1_ff <= qy_in;
         e0x1_ff <= dif(req_cx, req_ax); e0y1_ff <= dif(req_cy, req_ay);
         e1x1_ff <= dif(req_bx, req_ax); e1y1_ff <= dif(req_by, req_ay);
      end
   end

   // ---------------- Stage 2: all products ----------------
   // Side tests: j=0 left uses (tp*hx, hy*lp, bp*hx); j=2 right uses hy*rp;
   // j=1 top uses (lp*vy, tp*vx, rp*vy); j=3 bottom uses bp*vx.
   tbo_pkg::prod_type tph2_ff [3], bph2_ff [3], hyl2_ff [3], hyr2_ff [3];
   tbo_pkg::prod_type lpv2_ff [3], rpv2_ff [3], tpv2_ff [3], bpv2_ff [3];
   tbo_pkg::prod_type nua2_ff [4], nub2_ff [4], nva2_ff [4], nvb2_ff [4];
   tbo_pkg::prod_type dna2_ff, dnb2_ff;
   logic [3:0] fl2_ff [3];
   logic vert2_ff [3], vhit2_ff [3], dyz2_ff [3];
   logic vtx2_ff, bb2_ff;

   function automatic tbo_pkg::prod_type mul(tbo_pkg::diff_type a, tbo_pkg::diff_type b);
      return tbo_pkg::prod_type'(a) * tbo_pkg::prod_type'(b);
   endfunction

   always_ff @(posedge clock) begin
      if (en2) begin
         for (int e = 0; e < 3; e++) begin
            tph2_ff[e] <= mul(tp1_ff[e], hx1_ff[e]);
            bph2_ff[e] <= mul(bp1_ff[e], hx1_ff[e]);
            hyl2_ff[e] <= mul(hy1_ff[e], lp1_ff[e]);
            hyr2_ff[e] <= mul(hy1_ff[e], rp1_ff[e]);
            lpv2_ff[e] <= mul(lp1_ff[e], vy1_ff[e]);
            rpv2_ff[e] <= mul(rp1_ff[e], vy1_ff[e]);
            tpv2_ff[e] <= mul(tp1_ff[e], vx1_ff[e]);
            bpv2_ff[e] <= mul(bp1_ff[e], vx1_ff[e]);
         end
         for (int c = 0; c < 4; c++) begin
            nua2_ff[c] <= mul(qx1_ff[c], e1y1_ff);
            nub2_ff[c] <= mul(qy1_ff[c], e1x1_ff);
            nva2_ff[c] <= mul(e0x1_ff, qy1_ff[c]);
            nvb2_ff[c] <= mul(e0y1_ff, qx1_ff[c]);
         end
         dna2_ff <= mul(e0x1_ff, e1y1_ff);
         dnb2_ff <= mul(e0y1_ff, e1x1_ff);
         fl2_ff <= fl1_ff; vert2_ff <= vert1_ff; vhit2_ff <= vhit1_ff;
         dyz2_ff <= dyz1_ff; vtx2_ff <= vtx1_ff; bb2_ff <= bb1_ff;
      end
   end

   // ---------------- Stage 3: edge compares, barycentric sums ----------------
   logic ehit_in, ehit3_ff, vtx3_ff, bb3_ff;
   tbo_pkg::sum_type nu_in [4], nv_in [4], nu3_ff [4], nv3_ff [4];
   tbo_pkg::sum_type den_in, den3_ff;

   function automatic logic btw(tbo_pkg::prod_type lo, tbo_pkg::prod_type m,
                                tbo_pkg::prod_type hi);
      return (lo <= m) && (m <= hi);
   endfunction

   always_comb begin
      ehit_in = 1'b0;
      for (int e = 0; e < 3; e++) begin
         logic s0, s1, s2, s3, h;
         s0 = fl2_ff[e][0] && btw(tph2_ff[e], hyl2_ff[e], bph2_ff[e]);
         s2 = fl2_ff[e][2] && btw(tph2_ff[e], hyr2_ff[e], bph2_ff[e]);
         s1 = fl2_ff[e][1] && btw(lpv2_ff[e], tpv2_ff[e], rpv2_ff[e]);
         s3 = fl2_ff[e][3] && btw(lpv2_ff[e], bpv2_ff[e], rpv2_ff[e]);
         if (fl2_ff[e] == 4'd0) h = 1'b0;
         else if (vert2_ff[e]) h = vhit2_ff[e];
         else if (dyz2_ff[e]) h = s0 || s2;
         else h = s0 || s1 || s2 || s3;
         ehit_in = ehit_in || h;
      end
      for (int c = 0; c < 4; c++) begin
         nu_in[c] = tbo_pkg::sum_type'(nua2_ff[c]) - tbo_pkg::sum_type'(nub2_ff[c]);
         nv_in[c] = tbo_pkg::sum_type'(nva2_ff[c]) - tbo_pkg::sum_type'(nvb2_ff[c]);
      end
      den_in = tbo_pkg::sum_type'(dna2_ff) - tbo_pkg::sum_type'(dnb2_ff);
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         ehit3_ff <= ehit_in; vtx3_ff <= vtx2_ff; bb3_ff <= bb2_ff;
         nu3_ff <= nu_in; nv3_ff <= nv_in; den3_ff <= den_in;
      end
   end

   // ---------------- Stage 4: corner test and priority ----------------
   logic corner_in;
   tbo_pkg::hit_type kind_in, kind4_ff;
   always_comb begin
      logic neg;
      neg = den3_ff[tbo_pkg::SUM_WIDTH-1];
      corner_in = 1'b0;
      for (int c = 0; c < 4; c++) begin
         logic [tbo_pkg::SUM_WIDTH:0] su;
         logic ok;
         su = {nu3_ff[c][tbo_pkg::SUM_WIDTH-1], nu3_ff[c]}
            + {nv3_ff[c][tbo_pkg::SUM_WIDTH-1], nv3_ff[c]};
         // With a negative denominator all three comparisons flip direction.
         if (neg)
            ok = (nu3_ff[c] <= 0) && (nv3_ff[c] <= 0) && ($signed(su) >=
               $signed({den3_ff[tbo_pkg::SUM_WIDTH-1], den3_ff}));
         else
            ok = (nu3_ff[c] >= 0) && (nv3_ff[c] >= 0) && ($signed(su) <=
               $signed({den3_ff[tbo_pkg::SUM_WIDTH-1], den3_ff}));
         corner_in = corner_in || ok;
      end
      corner_in = corner_in && bb3_ff && (den3_ff != '0);
      if (vtx3_ff) kind_in = tbo_pkg::HIT_VERTEX;
      else if (ehit3_ff) kind_in = tbo_pkg::HIT_EDGE;
      else if (corner_in) kind_in = tbo_pkg::HIT_CORNER;
      else kind_in = tbo_pkg::HIT_NONE;
   end

   always_ff @(posedge clock) begin
      if (en4) kind4_ff <= kind_in;
   end

   assign rsp_valid = v4_ff;
   assign rsp_hit_kind = kind4_ff;
   assign rsp_overlap = (kind4_ff != tbo_pkg::HIT_NONE);

   `ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_hit_kind), "stalled result changed")
   `ASSERT_IMPL(a_ready_free, clock, reset, !v1_ff, req_ready,
      "ready low with empty first stage")
   `ASSERT_NEXT(a_flow, clock, reset, req_valid && req_ready, v1_ff, "accepted item lost")
endmodule
`default_nettype wire

/* tb/triangle_box_overlap_2d_checker.sv */
`timescale 1ns / 100ps
module triangle_box_overlap_2d_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_ready,
   input  wire tbo_pkg::coord_type req_box_left,
   input  wire tbo_pkg::coord_type req_box_top,
   input  wire tbo_pkg::coord_type req_box_right,
   input  wire tbo_pkg::coord_type req_box_bottom,
   input  wire tbo_pkg::coord_type req_ax,
   input  wire tbo_pkg::coord_type req_ay,
   input  wire tbo_pkg::coord_type req_bx,
   input  wire tbo_pkg::coord_type req_by,
   input  wire tbo_pkg::coord_type req_cx,
   input  wire tbo_pkg::coord_type req_cy,
   input  wire logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire logic rsp_overlap,
   input  wire logic [1:0] rsp_hit_kind,
   output int error_count,
   output int pending_count,
   output int hit_counts [4]
);
   tbo_pkg::hit_type pending_hits [$];

   function automatic logic [3:0] region_code(longint x, longint y, longint l, longint t,
                                              longint r, longint b);
      return {y > b, x > r, y > t, x > l};
   endfunction

   // Products fit easily in 128 signed bits.
   function automatic logic signed [127:0] mul(longint a, longint b);
      logic signed [127:0] pa;
      logic signed [127:0] pb;
      pa = a;
      pb = b;
      return pa * pb;
   endfunction

   function automatic bit in_span(logic signed [127:0] lo, logic signed [127:0] mid,
                                  logic signed [127:0] hi);
      return lo <= mid && mid <= hi;
   endfunction

   function automatic bit edge_crosses(longint px, longint py, longint qx, longint qy,
                                       logic [3:0] flags, longint l, longint t,
                                       longint r, longint b);
      longint dx;
      longint dy;
      longint hx;
      longint hy;
      longint vx;
      longint vy;
      dx = qx - px;
      dy = qy - py;
      if (flags == 0) return 0;
      if (dx == 0) return px == l || px == r || (px > l && px < r);
      hx = dx < 0 ? -dx : dx;
      hy = dx < 0 ? -dy : dy;
      vx = dy < 0 ? -dx : dx;
      vy = dy < 0 ? -dy : dy;
      if (flags[0] && in_span(mul(t - py, hx), mul(hy, l - px), mul(b - py, hx))) return 1;
      if (dy != 0) begin
         if (flags[1] && in_span(mul(l - px, vy), mul(t - py, vx), mul(r - px, vy))) return 1;
         if (flags[2] && in_span(mul(t - py, hx), mul(hy, r - px), mul(b - py, hx))) return 1;
         if (flags[3] && in_span(mul(l - px, vy), mul(b - py, vx), mul(r - px, vy))) return 1;
      end else if (flags[2] && in_span(mul(t - py, hx), mul(hy, r - px), mul(b - py, hx))) begin
         return 1;
      end
      return 0;
   endfunction

   function automatic bit point_in_tri(longint qx, longint qy, longint ax, longint ay,
                                       longint e0x, longint e0y, longint e1x, longint e1y,
                                       logic signed [127:0] area);
      logic signed [127:0] nu;
      logic signed [127:0] nv;
      nu = mul(qx - ax, e1y) - mul(qy - ay, e1x);
      nv = mul(e0x, qy - ay) - mul(e0y, qx - ax);
      if (area == 0) return 0;
      if (area < 0) begin
         nu = -nu;
         nv = -nv;
         area = -area;
      end
      return nu >= 0 && nv >= 0 && nu + nv <= area;
   endfunction

   function automatic tbo_pkg::hit_type classify_overlap(longint l, longint t, longint r,
                                                         longint b, longint ax, longint ay,
                                                         longint bx, longint by,
                                                         longint cx, longint cy);
      logic [3:0] ka;
      logic [3:0] kb;
      logic [3:0] kc;
      longint e0x;
      longint e0y;
      longint e1x;
      longint e1y;
      logic signed [127:0] area;
      ka = region_code(ax, ay, l, t, r, b);
      kb = region_code(bx, by, l, t, r, b);
      kc = region_code(cx, cy, l, t, r, b);
      if (ka == 4'd3 || kb == 4'd3 || kc == 4'd3) return tbo_pkg::HIT_VERTEX;
      if (edge_crosses(ax, ay, bx, by, ka ^ kb, l, t, r, b)) return tbo_pkg::HIT_EDGE;
      if (edge_crosses(bx, by, cx, cy, kb ^ kc, l, t, r, b)) return tbo_pkg::HIT_EDGE;
      if (edge_crosses(ax, ay, cx, cy, ka ^ kc, l, t, r, b)) return tbo_pkg::HIT_EDGE;
      if ((ax <= l || bx <= l || cx <= l) && (ax >= r || bx >= r || cx >= r) &&
          (ay <= t || by <= t || cy <= t) && (ay >= b || by >= b || cy >= b)) begin
         e0x = cx - ax;
         e0y = cy - ay;
         e1x = bx - ax;
         e1y = by - ay;
         area = mul(e0x, e1y) - mul(e0y, e1x);
         if (point_in_tri(l, t, ax, ay, e0x, e0y, e1x, e1y, area) ||
             point_in_tri(l, b, ax, ay, e0x, e0y, e1x, e1y, area) ||
             point_in_tri(r, b, ax, ay, e0x, e0y, e1x, e1y, area) ||
             point_in_tri(r, t, ax, ay, e0x, e0y, e1x, e1y, area))
            return tbo_pkg::HIT_CORNER;
      end
      return tbo_pkg::HIT_NONE;
   endfunction

   always @(posedge clock) begin
      tbo_pkg::hit_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            pending_hits.insert(pending_hits.size(), classify_overlap(req_box_left,
               req_box_top, req_box_right, req_box_bottom, req_ax, req_ay, req_bx, req_by,
               req_cx, req_cy));
         if (rsp_valid && rsp_ready) begin
            if (pending_hits.size() == 0) begin
               error_count++;
               if (error_count <= 10) $display("unexpected result transfer at %0t", $realtime);
            end else begin
               want = pending_hits.pop_front();
               hit_counts[want]++;
               if (rsp_overlap !== (want != tbo_pkg::HIT_NONE) || rsp_hit_kind !== want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("result mismatch: expected overlap=%0d kind=%0d, got %b %b",
                              want != tbo_pkg::HIT_NONE, want, rsp_overlap, rsp_hit_kind);
               end
            end
         end
      end
      pending_count = pending_hits.size();
   end
endmodule

/* tb/triangle_box_overlap_2d_tb.sv */
`timescale 1ns / 100ps
module triangle_box_overlap_2d_tb;
   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   tbo_pkg::coord_type req_f [10];
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_overlap;
   logic [1:0] rsp_hit_kind;
   int error_count;
   int pending_count;
   int hit_counts [4];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_off = 0;
   int cycle_count = 0;
   int items_sent = 0;

   initial for (int i = 0; i < 10; i++) req_f[i] = '0;

   always #4 clock = ~clock;

   triangle_box_overlap_2d DUT (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_box_left(req_f[0]), .req_box_top(req_f[1]), .req_box_right(req_f[2]),
      .req_box_bottom(req_f[3]), .req_ax(req_f[4]), .req_ay(req_f[5]), .req_bx(req_f[6]),
      .req_by(req_f[7]), .req_cx(req_f[8]), .req_cy(req_f[9]), .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready), .rsp_overlap(rsp_overlap), .rsp_hit_kind(rsp_hit_kind));

   triangle_box_overlap_2d_checker checker_inst (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_box_left(req_f[0]), .req_box_top(req_f[1]), .req_box_right(req_f[2]),
      .req_box_bottom(req_f[3]), .req_ax(req_f[4]), .req_ay(req_f[5]), .req_bx(req_f[6]),
      .req_by(req_f[7]), .req_cx(req_f[8]), .req_cy(req_f[9]), .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready), .rsp_overlap(rsp_overlap), .rsp_hit_kind(rsp_hit_kind),
      .error_count(error_count), .pending_count(pending_count), .hit_counts(hit_counts));

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("triangle_box_overlap_2d: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_off) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Hands one item to the block; valid stays high until the transfer.
   task automatic send_item(input tbo_pkg::coord_type v [10]);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      for (int i = 0; i < 10; i++) req_f[i] <= v[i];
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   function automatic tbo_pkg::coord_type rand_coord(int mode);
      case (mode)
         0: return tbo_pkg::coord_type'($urandom);
         1: return tbo_pkg::coord_type'($urandom_range(64) - 32);
         2: return ($urandom_range(1)) ? 24'h7fffff : 24'h800000;
         default: return tbo_pkg::coord_type'($urandom_range(4000) - 2000);
      endcase
   endfunction

   // Box that is usually ordered, triangle scattered around it.
   task automatic send_random;
      tbo_pkg::coord_type v [10];
      tbo_pkg::coord_type t;
      int mode;
      mode = $urandom_range(9);
      for (int i = 0; i < 10; i++)
         v[i] = rand_coord(mode < 2 ? 0 : (mode < 3 ? $urandom_range(3) : (mode < 6 ? 1 : 3)));
      if ($urandom_range(9) != 0) begin
         if (v[0] > v[2]) begin t = v[0]; v[0] = v[2]; v[2] = t; end
         if (v[1] > v[3]) begin t = v[1]; v[1] = v[3]; v[3] = t; end
      end
      // Often make a vertical or horizontal edge, a flat triangle, or A on a box line.
      case ($urandom_range(7))
         0: v[6] = v[4];
         1: v[7] = v[5];
         2: begin v[8] = v[6]; v[9] = v[7]; end
         3: v[4] = v[0];
         4: v[5] = v[3];
         default: ;
      endcase
      send_item(v);
   endtask

   task automatic send_directed;
      tbo_pkg::coord_type d [22][10];
      d[0] = '{-10, -10, 10, 10, 0, 0, 50, 50, 50, -50};
      d[1] = '{-10, -10, 10, 10, 10, 10, 50, 50, 50, -50};
      d[2] = '{-10, -10, 10, 10, -10, 0, -50, 50, -50, -50};
      d[3] = '{-10, -10, 10, 10, -50, 0, 50, 0, 60, 60};
      d[4] = '{-10, -10, 10, 10, 0, -50, 0, 50, 60, 60};
      d[5] = '{-10, -10, 10, 10, 10, -50, 10, 50, 60, 60};
      d[6] = '{-10, -10, 10, 10, -10, -50, -10, 50, -60, 60};
      d[7] = '{-10, -10, 10, 10, -100, -100, 100, -100, 0, 100};
      d[8] = '{-10, -10, 10, 10, -100, -100, 100, 100, -100, 100};
      d[9] = '{-10, -10, 10, 10, -100, -100, 0, 0, 100, 100};
      d[10] = '{-10, -10, 10, 10, 20, 20, 30, 20, 20, 30};
      d[11] = '{10, 10, -10, -10, 0, 0, 5, 5, 1, 7};
      d[12] = '{24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff,
                24'h800000, 24'h800000, 0, 0};
      d[13] = '{0, 0, 0, 0, 24'h800000, 24'h800000, 24'h7fffff, 24'h800000, 0, 24'h7fffff};
      d[14] = '{24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000,
                24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000};
      d[15] = '{-10, -10, 10, 10, -50, 5, 50, 15, 0, 100};
      d[16] = '{-10, -10, 10, 10, -20, -20, 20, 0, -20, 20};
      d[17] = '{-10, -10, 10, 10, -30, 30, 30, -30, 40, 40};
      d[18] = '{-10, -10, 10, 10, -10, -10, 20, 20, 20, -10};
      d[19] = '{24'h555555, 24'haaaaaa, 24'h7fffff, 24'h7fffff, 24'haaaaaa, 24'h555555,
                24'h7fffff, 24'h800000, 24'h123456, 24'hfedcba};
      d[20] = '{-10, -10, 10, 10, -100, 10, 100, 10, 0, 20};
      d[21] = '{-10, -10, 10, 10, -1000, -1000, 1000, -1000, -1000, 1000};
      foreach (d[i]) send_item(d[i]);
   endtask

   task automatic run_phase(input int idle, input int stall, input int count);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (count) send_random();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_directed();
      run_phase(0, 0, 300);
      run_phase(75, 0, 300);
      run_phase(0, 75, 300);
      run_phase(31, 31, 300);
      // The receiver holds off for a while so the pipeline fills and stalls its input.
      fork
         begin
            hold_off = 1;
            repeat (60) @(posedge clock);
            hold_off = 0;
         end
         run_phase(0, 0, 40);
      join
      run_phase(0, 0, 260);
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("sent %0d items across idle and stall phases; kinds none/vertex/edge/corner:",
               items_sent);
      $display("   %0d / %0d / %0d / %0d", hit_counts[0], hit_counts[1], hit_counts[2],
               hit_counts[3]);
      if (error_count == 0) $display("triangle_box_overlap_2d: match");
      else $display("triangle_box_overlap_2d: mismatch");
      $finish;
   end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/tbo_pkg.sv
hw/rtl/triangle_box_overlap_2d.sv
tb/triangle_box_overlap_2d_checker.sv
tb/triangle_box_overlap_2d_tb.sv
